### hdl/dmlc_pkg.sv
// Shared types and constants for the dark/motion backlight controller.
// No dependencies; every other file of the block refers to this package by scoped names.
package dmlc_pkg;

   localparam int unsigned LightWidth  = 10;
   localparam int unsigned TickWidth   = 8;
   localparam int unsigned DutyWidth   = 8;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDatWidth = 10;

   localparam logic [CountWidth-1:0] CountMax       = 3'd5;
   localparam logic [CountWidth-1:0] DarkSetAbove   = 3'd3;
   localparam logic [CountWidth-1:0] MotionSetAbove = 3'd2;

   localparam logic [LightWidth-1:0] DarkUpperReset   = 10'd600;
   localparam logic [LightWidth-1:0] DarkLowerReset   = 10'd400;
   localparam logic [TickWidth-1:0]  LingerTicksReset = 8'd60;
   localparam logic [DutyWidth-1:0]  DutyLevelReset   = 8'd60;

   typedef enum logic [1:0] {
      CMD_LIGHT = 2'd0,
      CMD_PIN   = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_SLEEP  = 2'd0,
      MODE_IRQ    = 2'd1,
      MODE_SAMPLE = 2'd2
   } mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_DARK_UPPER   = 2'd0,
      REG_DARK_LOWER   = 2'd1,
      REG_LINGER_TICKS = 2'd2,
      REG_DUTY_LEVEL   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [LightWidth-1:0] dark_upper;
      logic [LightWidth-1:0] dark_lower;
      logic [TickWidth-1:0]  linger_ticks;
      logic [DutyWidth-1:0]  duty_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [LightWidth-1:0] light_sample;
      logic                  pin_level;
   } event_type;

   typedef struct packed {
      logic                 is_dark;
      logic                 in_motion;
      logic [1:0]           sensor_mode;
      logic                 pwm_enable;
      logic [DutyWidth-1:0] pwm_duty;
      logic                 pin_irq_enable;
   } status_type;

endpackage

### hdl/dmlc_if.sv
// Channel interfaces of the backlight controller: event, status and register write.
// Depends on dmlc_pkg for field widths.
interface dmlc_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     cmd;
   logic [dmlc_pkg::LightWidth-1:0] light_sample;
   logic                           pin_level;

   modport source (output valid, output cmd, output light_sample, output pin_level,
                   input ready);
   modport sink (input valid, input cmd, input light_sample, input pin_level,
                 output ready);
endinterface

interface dmlc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_dark;
   logic                          in_motion;
   logic [1:0]                    sensor_mode;
   logic                          pwm_enable;
   logic [dmlc_pkg::DutyWidth-1:0] pwm_duty;
   logic                          pin_irq_enable;

   modport source (output valid, output is_dark, output in_motion, output sensor_mode,
                   output pwm_enable, output pwm_duty, output pin_irq_enable,
                   input ready);
   modport sink (input valid, input is_dark, input in_motion, input sensor_mode,
                 input pwm_enable, input pwm_duty, input pin_irq_enable,
                 output ready);
endinterface

interface dmlc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dmlc_pkg::CsrIdxWidth-1:0] index;
   logic [dmlc_pkg::CsrDatWidth-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/dmlc_csr_regs.sv
// Configuration register file: thresholds, motion timeout and duty level.
// Depends on dmlc_pkg and the dmlc_csr_if interface.
module dmlc_csr_regs (
   input  logic                clock,
   input  logic                reset,
   dmlc_csr_if.sink            csr_chan,
   output dmlc_pkg::cfg_type   cfg
);

   dmlc_pkg::cfg_type cfg_ff;
   dmlc_pkg::cfg_type cfg_in;
   logic              wr_fire;

   assign csr_chan.ready = 1'b1;
   assign wr_fire        = csr_chan.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (dmlc_pkg::reg_index_type'(csr_chan.index))
            dmlc_pkg::REG_DARK_UPPER:     cfg_in.dark_upper     = csr_chan.data;
            dmlc_pkg::REG_DARK_LOWER:     cfg_in.dark_lower     = csr_chan.data;
            dmlc_pkg::REG_LINGER_TICKS:
               cfg_in.linger_ticks = csr_chan.data[dmlc_pkg::TickWidth-1:0];
            dmlc_pkg::REG_DUTY_LEVEL:
               cfg_in.duty_level = csr_chan.data[dmlc_pkg::DutyWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_upper   <= dmlc_pkg::DarkUpperReset;
         cfg_ff.dark_lower   <= dmlc_pkg::DarkLowerReset;
         cfg_ff.linger_ticks <= dmlc_pkg::LingerTicksReset;
         cfg_ff.duty_level   <= dmlc_pkg::DutyLevelReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/dmlc_ctrl_state.sv
// Controller state and its one-event update: dark/motion qualifiers, timeout, mode.
// Depends on dmlc_pkg.
module dmlc_ctrl_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dmlc_pkg::event_type   evt,
   input  dmlc_pkg::cfg_type     cfg,
   output dmlc_pkg::status_type  status
);

   logic [dmlc_pkg::CountWidth-1:0] dark_count_ff,   dark_count_in;
   logic                            dark_flag_ff,    dark_flag_in;
   logic [dmlc_pkg::CountWidth-1:0] motion_count_ff, motion_count_in;
   logic                            motion_flag_ff,  motion_flag_in;
   logic [dmlc_pkg::TickWidth-1:0]  ticks_left_ff,   ticks_left_in;
   dmlc_pkg::mode_type              mode_ff,         mode_in;
   logic                            pwm_on_ff,       pwm_on_in;
   logic                            irq_on_ff,       irq_on_in;

   logic                            vote;
   logic [dmlc_pkg::CountWidth-1:0] dark_count_nx;
   logic                            dark_flag_nx;
   logic [dmlc_pkg::CountWidth-1:0] motion_count_nx;

   always_comb begin
      // hysteresis: upper threshold to go dark, lower to go bright
      if (dark_flag_ff) begin
         vote = !(evt.light_sample < cfg.dark_lower);
      end else begin
         vote = evt.light_sample > cfg.dark_upper;
      end

      if (vote) begin
         dark_count_nx = (dark_count_ff < dmlc_pkg::CountMax) ?
                         dark_count_ff + 3'd1 : dark_count_ff;
         dark_flag_nx  = dark_flag_ff | (dark_count_nx > dmlc_pkg::DarkSetAbove);
      end else begin
         dark_count_nx = (dark_count_ff != 3'd0) ? dark_count_ff - 3'd1 : dark_count_ff;
         dark_flag_nx  = dark_flag_ff & (dark_count_nx != 3'd0);
      end

      motion_count_nx = (motion_count_ff < dmlc_pkg::CountMax) ?
                        motion_count_ff + 3'd1 : motion_count_ff;

      dark_count_in   = dark_count_ff;
      dark_flag_in    = dark_flag_ff;
      motion_count_in = motion_count_ff;
      motion_flag_in  = motion_flag_ff;
      ticks_left_in   = ticks_left_ff;
      mode_in         = mode_ff;
      pwm_on_in       = pwm_on_ff;
      irq_on_in       = irq_on_ff;

      case (dmlc_pkg::cmd_type'(evt.cmd))
         dmlc_pkg::CMD_LIGHT: begin
            dark_count_in = dark_count_nx;
            dark_flag_in  = dark_flag_nx;
            if (motion_flag_ff && dark_flag_nx) begin
               if (mode_ff != dmlc_pkg::MODE_SAMPLE) begin
                  mode_in   = dmlc_pkg::MODE_SAMPLE;
                  pwm_on_in = 1'b1;
               end
               // timeout expired: drop motion and turn the light off
               if (ticks_left_ff == '0) begin
                  motion_flag_in  = 1'b0;
                  pwm_on_in       = 1'b0;
                  motion_count_in = '0;
               end
            end else if (dark_flag_nx) begin
               irq_on_in = 1'b1;
               mode_in   = dmlc_pkg::MODE_IRQ;
            end else begin
               irq_on_in = 1'b0;
               mode_in   = dmlc_pkg::MODE_SLEEP;
            end
         end
         dmlc_pkg::CMD_PIN: begin
            if (irq_on_ff && evt.pin_level) begin
               motion_count_in = motion_count_nx;
               if (motion_count_nx > dmlc_pkg::MotionSetAbove) begin
                  motion_flag_in = 1'b1;
                  ticks_left_in  = cfg.linger_ticks;
               end
            end
         end
         dmlc_pkg::CMD_TICK: begin
            if (ticks_left_ff != '0) begin
               ticks_left_in = ticks_left_ff - 8'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_count_ff   <= '0;
         dark_flag_ff    <= 1'b0;
         motion_count_ff <= '0;
         motion_flag_ff  <= 1'b0;
         ticks_left_ff   <= '0;
         mode_ff         <= dmlc_pkg::MODE_SLEEP;
         pwm_on_ff       <= 1'b0;
         irq_on_ff       <= 1'b0;
      end else if (step) begin
         dark_count_ff   <= dark_count_in;
         dark_flag_ff    <= dark_flag_in;
         motion_count_ff <= motion_count_in;
         motion_flag_ff  <= motion_flag_in;
         ticks_left_ff   <= ticks_left_in;
         mode_ff         <= mode_in;
         pwm_on_ff       <= pwm_on_in;
         irq_on_ff       <= irq_on_in;
      end
   end

   // status after the event, for the result register
   always_comb begin
      status.is_dark        = dark_flag_in;
      status.in_motion      = motion_flag_in;
      status.sensor_mode    = mode_in;
      status.pwm_enable     = pwm_on_in;
      status.pwm_duty       = pwm_on_in ? cfg.duty_level : '0;
      status.pin_irq_enable = irq_on_in;
   end

endmodule

### hdl/dark_motion_light_controller_core.sv
// Top level of the dark/motion backlight controller: event register, state update,
// status register. Depends on dmlc_pkg, dmlc_if, dmlc_csr_regs and dmlc_ctrl_state.
//
//   port      dir   beat carries
//   --------  ----  --------------------------------------------------------------
//   req_chan  in    cmd, light_sample, pin_level (light sample, pin change, tick)
//   rsp_chan  out   is_dark, in_motion, sensor_mode, pwm_enable, pwm_duty,
//                   pin_irq_enable (status after the event)
//   csr_chan  in    index, data (register write, always ready)
//
// One beat per cycle sustained while rsp_chan is ready. An accepted event lands in the
// event register; when the status register advances, it is applied to the state and
// its status is captured in the status register, which raises rsp_chan.valid. The
// event register and the status register form a two-stage pipeline, so a stalled
// rsp_chan only holds req_chan once both stages are full. Synchronous reset clears the
// state, empties both stages and loads the register reset values.
module dark_motion_light_controller_core (
   input  logic        clock,
   input  logic        reset,
   dmlc_req_if.sink    req_chan,
   dmlc_rsp_if.source  rsp_chan,
   dmlc_csr_if.sink    csr_chan
);

   dmlc_pkg::cfg_type    cfg;
   dmlc_pkg::status_type status;

   // event register
   logic                 evt_valid_ff, evt_valid_in;
   dmlc_pkg::event_type  evt_ff;

   // status register
   logic                 rsp_valid_ff, rsp_valid_in;
   dmlc_pkg::status_type rsp_data_ff;

   logic req_fire;
   logic advance;
   logic step;

   dmlc_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   dmlc_ctrl_state u_ctrl_state (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .evt    (evt_ff),
      .cfg    (cfg),
      .status (status)
   );

   // advance the status register when it is empty or being drained
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign step           = evt_valid_ff && advance;
   assign req_chan.ready = !evt_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      evt_valid_in = evt_valid_ff;
      if (req_fire) begin
         evt_valid_in = 1'b1;
      end else if (advance) begin
         evt_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold unless a new beat moves in
   always_ff @(posedge clock) begin
      if (req_fire) begin
         evt_ff.cmd          <= req_chan.cmd;
         evt_ff.light_sample <= req_chan.light_sample;
         evt_ff.pin_level    <= req_chan.pin_level;
      end
      if (step) begin
         rsp_data_ff <= status;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.is_dark        = rsp_data_ff.is_dark;
   assign rsp_chan.in_motion      = rsp_data_ff.in_motion;
   assign rsp_chan.sensor_mode    = rsp_data_ff.sensor_mode;
   assign rsp_chan.pwm_enable     = rsp_data_ff.pwm_enable;
   assign rsp_chan.pwm_duty       = rsp_data_ff.pwm_duty;
   assign rsp_chan.pin_irq_enable = rsp_data_ff.pin_irq_enable;

endmodule
